### hw/rtl/serial_frame_receiver_core_assert.svh
// Assertion macros for the checker file of the frame receiver.
`ifndef SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sfr_pkg.sv
package sfr_pkg;

    localparam logic [7:0]  HDR_FIRST   = 8'hA5;
    localparam logic [7:0]  HDR_SECOND  = 8'h5A;
    localparam logic [7:0]  TRAILER     = 8'hFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam int          MAX_RESULTS = 64;
    localparam int          POS_W       = 8;

    typedef enum logic [2:0] {
        CFG_EXP_CMD   = 3'd0,
        CFG_FLAG_CNT  = 3'd1,
        CFG_BYTE_CNT  = 3'd2,
        CFG_HALF_CNT  = 3'd3,
        CFG_WORD_CNT  = 3'd4,
        CFG_FLOAT_CNT = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_FLAG  = 3'd0,
        K_INT8  = 3'd1,
        K_INT16 = 3'd2,
        K_INT32 = 3'd3,
        K_FLOAT = 3'd4,
        K_EMPTY = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        D_HUNT,
        D_SYNC,
        D_LEN,
        D_CMD,
        D_PAY,
        D_CRC_HI,
        D_CRC_LO,
        D_TRAIL
    } t_dstate;

    typedef enum logic [1:0] {
        U_IDLE,
        U_READ,
        U_ACC,
        U_EMIT
    } t_ustate;

    typedef struct packed {
        logic       bad;
        logic [9:0] exp_len;
        logic [7:0] cmd;
    } t_frame_cfg;

    typedef struct packed {
        logic [4:0] fbytes;
        logic [2:0] flag_rem;
        logic [6:0] bytes;
        logic [5:0] halves;
        logic [4:0] words;
        logic [4:0] floats;
    } t_unpack_cfg;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } t_ram_wr;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  idx;
        logic [31:0] value;
        logic [7:0]  mask;
        logic [7:0]  cmd;
        logic        last;
    } t_result;

    // One byte of CRC-16/Modbus, reflected, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hw/rtl/serial_frame_receiver_core.sv
// Byte-stream frame receiver with CRC-16/Modbus check and payload unpacking.
// Slave stream: one received byte per transfer in s_axis_tdata[7:0]. Bytes are taken one per
// cycle while no frame is being unpacked. Frames are A5 5A, length, command, payload,
// CRC high, CRC low, FF; the CRC covers the payload only.
// Configuration channel: i_cfg_index selects a register (expected command, then the flag,
// int8, int16, int32 and float counts), i_cfg_data carries the value; it is always ready.
// Master stream: one transfer per unpacked element, tuser holds the element kind, tlast marks
// the final element of the frame. An empty frame yields a single kind-5 transfer.
// The first result follows the trailer transfer through the read, accumulate and emit
// steps of the unpacker (an empty frame goes straight to the emit step). Each element is
// read one byte at a time through the single read port of the payload memory, a read and
// an accumulate step per byte, and then passes the emit step.
// The slave side is not ready from the cycle after a good trailer until the last result of
// that frame sits in the output register.
// A stalled master side holds the current result and pauses the unpacking walk.
// Reset returns the hunt to searching, clears all configuration registers and drops any
// pending result; the payload memory is not cleared and needs no clearing pass.
module serial_frame_receiver_core import sfr_pkg::*; #(
    parameter int PAYLOAD_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] index, [37:6] value, [45:38] flag mask,
                                        // [53:46] frame command, [55:54] zero
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser,   // [2:0] element kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_exp_cmd;
    logic [6:0] r_flag_cnt;
    logic [6:0] r_byte_cnt;
    logic [5:0] r_half_cnt;
    logic [4:0] r_word_cnt;
    logic [4:0] r_float_cnt;

    logic [4:0]       fbytes;
    logic [9:0]       exp_len;
    logic [8:0]       nelem;
    t_frame_cfg       frame_cfg;
    t_unpack_cfg      unpack_cfg;
    t_ram_wr          ram_wr;
    logic [POS_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             start;
    logic [7:0]       frame_cmd;
    logic             busy;
    logic             in_xfer;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd   <= '0;
            r_flag_cnt  <= '0;
            r_byte_cnt  <= '0;
            r_half_cnt  <= '0;
            r_word_cnt  <= '0;
            r_float_cnt <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EXP_CMD:   r_exp_cmd   <= i_cfg_data;
                CFG_FLAG_CNT:  r_flag_cnt  <= i_cfg_data[6:0];
                CFG_BYTE_CNT:  r_byte_cnt  <= i_cfg_data[6:0];
                CFG_HALF_CNT:  r_half_cnt  <= i_cfg_data[5:0];
                CFG_WORD_CNT:  r_word_cnt  <= i_cfg_data[4:0];
                CFG_FLOAT_CNT: r_float_cnt <= i_cfg_data[4:0];
                default:       r_exp_cmd   <= r_exp_cmd;
            endcase
        end
    end

    assign fbytes  = 5'(({1'b0, r_flag_cnt} + 8'd7) >> 3);
    assign exp_len = 10'(fbytes) + 10'(r_byte_cnt) + 10'({r_half_cnt, 1'b0})
                     + 10'({r_word_cnt, 2'b00}) + 10'({r_float_cnt, 2'b00});
    assign nelem   = 9'(fbytes) + 9'(r_byte_cnt) + 9'(r_half_cnt) + 9'(r_word_cnt)
                     + 9'(r_float_cnt);

    assign frame_cfg.bad     = (exp_len > 10'(PAYLOAD_MAX)) || (nelem > 9'(MAX_RESULTS));
    assign frame_cfg.exp_len = exp_len;
    assign frame_cfg.cmd     = r_exp_cmd;

    assign unpack_cfg.fbytes   = fbytes;
    assign unpack_cfg.flag_rem = r_flag_cnt[2:0];
    assign unpack_cfg.bytes    = r_byte_cnt;
    assign unpack_cfg.halves   = r_half_cnt;
    assign unpack_cfg.words    = r_word_cnt;
    assign unpack_cfg.floats   = r_float_cnt;

    assign s_axis_tready = !busy;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    sfr_deframer u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_byte  (s_axis_tdata),
        .i_cfg   (frame_cfg),
        .o_wr    (ram_wr),
        .o_start (start),
        .o_cmd   (frame_cmd)
    );

    sfr_payload_ram #(
        .DEPTH (PAYLOAD_MAX)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfr_unpacker u_unpacker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (frame_cmd),
        .i_cfg       (unpack_cfg),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_busy      (busy),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {2'b00, res.cmd, res.mask, res.value, res.idx};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.kind;

endmodule

### hw/rtl/sfr_payload_ram.sv
module sfr_payload_ram import sfr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  t_ram_wr          i_wr,
    input  logic [POS_W-1:0] i_rd_addr,
    output logic [7:0]       o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/sfr_deframer.sv
module sfr_deframer import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  t_frame_cfg i_cfg,
    output t_ram_wr    o_wr,
    output logic       o_start,
    output logic [7:0] o_cmd
);

    t_dstate           r_state, n_state;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic [7:0]        r_len, n_len;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_cmd, n_cmd;
    logic [15:0]       r_rcrc, n_rcrc;
    logic              len_ok;
    logic              trail_good;

    assign len_ok     = ({2'b00, i_byte} == i_cfg.exp_len);
    assign trail_good = (i_byte == TRAILER) && (r_cmd == i_cfg.cmd) && (r_rcrc == r_crc)
                        && ({2'b00, r_len} == i_cfg.exp_len);

    always_comb begin
        n_state = r_state;
        if (i_valid) begin
            if (i_cfg.bad) begin
                n_state = D_HUNT;
            end else begin
                case (r_state)
                    D_HUNT:   n_state = (i_byte == HDR_FIRST) ? D_SYNC : D_HUNT;
                    D_SYNC: begin
                        if (i_byte == HDR_SECOND) begin
                            n_state = D_LEN;
                        end else if (i_byte == HDR_FIRST) begin
                            n_state = D_SYNC;
                        end else begin
                            n_state = D_HUNT;
                        end
                    end
                    D_LEN:    n_state = len_ok ? D_CMD : D_HUNT;
                    D_CMD:    n_state = (r_len == '0) ? D_CRC_HI : D_PAY;
                    D_PAY:    n_state = (r_cnt == r_len - 8'd1) ? D_CRC_HI : D_PAY;
                    D_CRC_HI: n_state = D_CRC_LO;
                    D_CRC_LO: n_state = D_TRAIL;
                    D_TRAIL:  n_state = D_HUNT;
                    default:  n_state = D_HUNT;
                endcase
            end
        end
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_crc   = r_crc;
        n_cmd   = r_cmd;
        n_rcrc  = r_rcrc;
        o_wr    = '0;
        o_start = 1'b0;
        if (i_valid && !i_cfg.bad) begin
            case (r_state)
                D_SYNC: begin
                    n_crc = CRC_INIT;
                end
                D_LEN: begin
                    n_len = i_byte;
                    n_cnt = '0;
                end
                D_CMD: begin
                    n_cmd = i_byte;
                end
                D_PAY: begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_cnt;
                    o_wr.data = i_byte;
                    n_crc     = crc16_byte(r_crc, i_byte);
                    n_cnt     = r_cnt + 1'b1;
                end
                D_CRC_HI: begin
                    n_rcrc = {i_byte, 8'h00};
                end
                D_CRC_LO: begin
                    n_rcrc = {r_rcrc[15:8], i_byte};
                end
                D_TRAIL: begin
                    o_start = trail_good;
                end
                default: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_len  <= n_len;
        r_crc  <= n_crc;
        r_cmd  <= n_cmd;
        r_rcrc <= n_rcrc;
    end

    assign o_cmd = r_cmd;

endmodule

### hw/rtl/sfr_unpacker.sv
module sfr_unpacker import sfr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [7:0]       i_cmd,
    input  t_unpack_cfg      i_cfg,
    output logic [POS_W-1:0] o_rd_addr,
    input  logic [7:0]       i_rd_data,
    output logic             o_busy,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    t_ustate          r_state, n_state;
    t_kind            r_kind, n_kind;
    logic [6:0]       r_idx, n_idx;
    logic [1:0]       r_bnum, n_bnum;
    logic [POS_W-1:0] r_addr, n_addr;
    logic [31:0]      r_acc, n_acc;
    logic [7:0]       r_cmd, n_cmd;
    logic             r_ovalid, n_ovalid;
    t_result          r_res, n_res;

    logic [4:0] avail;
    logic [6:0] cur_count;
    logic [1:0] width_m1;
    t_kind      first_kind;
    t_kind      after_kind;
    logic       elem_done;
    logic       last_elem;
    logic       out_free;
    logic [7:0] flag_mask;

    // Lowest kind at or above 'from' that has elements; K_EMPTY when none is left.
    function automatic t_kind next_kind(input logic [4:0] av, input logic [2:0] from);
        t_kind nk;
        nk = K_EMPTY;
        for (int k = 4; k >= 0; k--) begin
            if (av[k] && (3'(k) >= from)) begin
                nk = t_kind'(3'(k));
            end
        end
        return nk;
    endfunction

    assign avail = {i_cfg.floats != '0, i_cfg.words != '0, i_cfg.halves != '0,
                    i_cfg.bytes != '0, i_cfg.fbytes != '0};

    always_comb begin
        case (r_kind)
            K_FLAG:  begin cur_count = {2'b00, i_cfg.fbytes};  width_m1 = 2'd0; end
            K_INT8:  begin cur_count = i_cfg.bytes;             width_m1 = 2'd0; end
            K_INT16: begin cur_count = {1'b0, i_cfg.halves};    width_m1 = 2'd1; end
            K_INT32: begin cur_count = {2'b00, i_cfg.words};    width_m1 = 2'd3; end
            K_FLOAT: begin cur_count = {2'b00, i_cfg.floats};   width_m1 = 2'd3; end
            default: begin cur_count = 7'd0;                    width_m1 = 2'd0; end
        endcase
    end

    assign first_kind = next_kind(avail, 3'd0);
    assign after_kind = next_kind(avail, r_kind + 3'd1);
    assign elem_done  = (r_idx + 7'd1 == cur_count);
    assign last_elem  = elem_done && (after_kind == K_EMPTY);
    assign out_free   = !r_ovalid || i_res_ready;

    // The last flag byte carries only the leftover flags when the count is not a multiple of 8.
    always_comb begin
        if ((r_idx[4:0] == i_cfg.fbytes - 5'd1) && (i_cfg.flag_rem != '0)) begin
            flag_mask = (8'h01 << i_cfg.flag_rem) - 8'h01;
        end else begin
            flag_mask = 8'hFF;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_state = (first_kind == K_EMPTY) ? U_EMIT : U_READ;
                end
            end
            U_READ:  n_state = U_ACC;
            U_ACC:   n_state = (r_bnum == width_m1) ? U_EMIT : U_READ;
            U_EMIT: begin
                if (out_free) begin
                    if (r_kind == K_EMPTY || last_elem) begin
                        n_state = U_IDLE;
                    end else begin
                        n_state = U_READ;
                    end
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_comb begin
        n_kind   = r_kind;
        n_idx    = r_idx;
        n_bnum   = r_bnum;
        n_addr   = r_addr;
        n_acc    = r_acc;
        n_cmd    = r_cmd;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_res_ready;
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_kind = first_kind;
                    n_idx  = '0;
                    n_bnum = '0;
                    n_addr = '0;
                    n_acc  = '0;
                    n_cmd  = i_cmd;
                end
            end
            U_ACC: begin
                n_acc  = {r_acc[23:0], i_rd_data};
                n_addr = r_addr + 1'b1;
                n_bnum = r_bnum + 2'd1;
            end
            U_EMIT: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_res.kind  = r_kind;
                    n_res.idx   = r_idx[5:0];
                    n_res.value = r_acc;
                    n_res.mask  = (r_kind == K_FLAG) ? flag_mask : 8'h00;
                    n_res.cmd   = r_cmd;
                    n_res.last  = (r_kind == K_EMPTY) || last_elem;
                    n_acc       = '0;
                    n_bnum      = '0;
                    if (elem_done) begin
                        n_kind = after_kind;
                        n_idx  = '0;
                    end else begin
                        n_idx = r_idx + 7'd1;
                    end
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= U_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_bnum <= n_bnum;
        r_addr <= n_addr;
        r_acc  <= n_acc;
        r_cmd  <= n_cmd;
        r_res  <= n_res;
    end

    assign o_rd_addr   = r_addr;
    assign o_busy      = (r_state != U_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

### hw/rtl/sfr_checker.sv
`include "serial_frame_receiver_core_assert.svh"

module sfr_checker import sfr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    logic out_stall;
    logic empty_res;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign empty_res = m_axis_tvalid && (m_axis_tuser == K_EMPTY);

    `SFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast), "stalled result changed")

    // While a frame still has results to come, the byte input must stay blocked.
    `SFR_ASSERT_IMP(a_no_rx_midframe, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        !s_axis_tready, "byte input ready while a frame is being unpacked")

    `SFR_ASSERT_IMP(a_empty_single, i_clk, i_rst_n, empty_res,
        m_axis_tlast && (m_axis_tdata[45:0] == 46'd0), "empty-frame result malformed")

    `SFR_ASSERT_IMP(a_mask_flags_only, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != K_FLAG),
        m_axis_tdata[45:38] == 8'h00, "flag mask set on a non-flag result")

    `SFR_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready,
        "configuration write refused")

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (.*);
